### hdl/gfq_pkg.sv
// types and codes shared by the team queue modules
`default_nettype none

package gfq_pkg;

   typedef enum logic [1:0] {
      OP_ASSIGN  = 2'd0,
      OP_ENQUEUE = 2'd1,
      OP_DEQUEUE = 2'd2,
      OP_CLEAR   = 2'd3
   } gfq_op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } gfq_status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_ASSIGN,
      CMD_ENQ_LOOKUP,
      CMD_ENQ_GROUP,
      CMD_ENQ_LINK,
      CMD_ENQ_TAIL,
      CMD_DEQ_ORDER,
      CMD_DEQ_GROUP,
      CMD_DEQ_NODE,
      CMD_DEQ_POP,
      CMD_SWEEP,
      CMD_RESULT
   } gfq_cmd_type;

   typedef struct packed {
      logic full;
      logic order_empty;
      logic waiting;
      logic sweep_done;
   } gfq_flags_type;

endpackage

`default_nettype wire

### hdl/gfq_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module gfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hdl/gfq_ctrl.sv
// sequencing state machine for the team queue
`default_nettype none

module gfq_ctrl
   import gfq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_operation,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output gfq_cmd_type        cmd,
   input  wire gfq_flags_type flags
);

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_ASSIGN,
      S_ENQ_LOOKUP,
      S_ENQ_GROUP,
      S_ENQ_LINK,
      S_ENQ_TAIL,
      S_DEQ_ORDER,
      S_DEQ_GROUP,
      S_DEQ_NODE,
      S_DEQ_POP,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      sweep_rsp_ff, sweep_rsp_in;
   logic      load_ok;

   // output register is free or being emptied this cycle
   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_rsp_in = sweep_rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = CMD_NONE;
      unique case (state_ff)
         S_SWEEP: begin
            cmd = CMD_SWEEP;
            if (flags.sweep_done) begin
               state_in = sweep_rsp_ff ? S_RESULT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd = CMD_CAPTURE;
               unique case (gfq_op_type'(req_operation))
                  OP_ASSIGN:  state_in = S_ASSIGN;
                  OP_ENQUEUE: state_in = S_ENQ_LOOKUP;
                  OP_DEQUEUE: state_in = S_DEQ_ORDER;
                  OP_CLEAR: begin
                     state_in     = S_SWEEP;
                     sweep_rsp_in = 1'b1;
                  end
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_ASSIGN: begin
            cmd      = CMD_ASSIGN;
            state_in = S_RESULT;
         end
         S_ENQ_LOOKUP: begin
            cmd      = CMD_ENQ_LOOKUP;
            state_in = S_ENQ_GROUP;
         end
         S_ENQ_GROUP: begin
            cmd      = CMD_ENQ_GROUP;
            state_in = flags.full ? S_RESULT : S_ENQ_LINK;
         end
         S_ENQ_LINK: begin
            cmd      = CMD_ENQ_LINK;
            state_in = flags.waiting ? S_ENQ_TAIL : S_RESULT;
         end
         S_ENQ_TAIL: begin
            cmd      = CMD_ENQ_TAIL;
            state_in = S_RESULT;
         end
         S_DEQ_ORDER: begin
            cmd      = CMD_DEQ_ORDER;
            state_in = flags.order_empty ? S_RESULT : S_DEQ_GROUP;
         end
         S_DEQ_GROUP: begin
            cmd      = CMD_DEQ_GROUP;
            state_in = S_DEQ_NODE;
         end
         S_DEQ_NODE: begin
            cmd      = CMD_DEQ_NODE;
            state_in = S_DEQ_POP;
         end
         S_DEQ_POP: begin
            cmd      = CMD_DEQ_POP;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (load_ok) begin
               cmd          = CMD_RESULT;
               rsp_valid_in = 1'b1;
               sweep_rsp_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_SWEEP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
         sweep_rsp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sweep_rsp_ff <= sweep_rsp_in;
      end
   end

endmodule

`default_nettype wire

### hdl/gfq_dpath.sv
// memories, pointers and result registers of the team queue
`default_nettype none

module gfq_dpath
   import gfq_pkg::*;
#(
   parameter int ELEMENT_COUNT = 1024,
   parameter int GROUP_COUNT   = 16,
   parameter int CAPACITY      = 256
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire gfq_cmd_type   cmd,
   output gfq_flags_type      flags,
   input  wire logic [9:0]    req_element,
   input  wire logic [3:0]    req_group,
   output logic      [9:0]    rsp_dequeued_element,
   output logic      [1:0]    rsp_status
);

   localparam int EW        = $clog2(ELEMENT_COUNT);
   localparam int GW        = $clog2(GROUP_COUNT);
   localparam int NW        = $clog2(CAPACITY);
   localparam int CW        = $clog2(CAPACITY + 1);
   localparam int OW        = $clog2(GROUP_COUNT + 1);
   localparam int GD        = 1 + 2 * NW;
   localparam int SWEEP_LEN = (ELEMENT_COUNT > GROUP_COUNT) ? ELEMENT_COUNT : GROUP_COUNT;
   localparam int SW        = $clog2(SWEEP_LEN);

   logic [9:0]     elem_ff;
   logic           in_range_ff;
   logic [GW-1:0]  grp_in_ff, grp_ff;
   logic [NW-1:0]  node_ff, tail_ff, free_head_ff;
   logic [CW-1:0]  fill_ff, stored_ff;
   logic [GW-1:0]  order_head_ff, order_tail_ff;
   logic [OW-1:0]  order_count_ff;
   logic [SW-1:0]  sweep_ff;
   gfq_status_type pend_status_ff, rsp_status_ff;
   logic [9:0]     pend_elem_ff, rsp_elem_ff;

   logic           mem_wr_en;
   logic [EW-1:0]  mem_wr_addr, mem_rd_addr;
   logic [GW-1:0]  mem_wr_data, mem_rd_data;
   logic           elm_wr_en;
   logic [NW-1:0]  elm_wr_addr, elm_rd_addr;
   logic [9:0]     elm_wr_data, elm_rd_data;
   logic           lnk_wr_en;
   logic [NW-1:0]  lnk_wr_addr, lnk_rd_addr, lnk_wr_data, lnk_rd_data;
   logic           grt_wr_en;
   logic [GW-1:0]  grt_wr_addr, grt_rd_addr;
   logic [GD-1:0]  grt_wr_data, grt_rd_data;
   logic           ord_wr_en;
   logic [GW-1:0]  ord_wr_addr, ord_rd_addr, ord_wr_data, ord_rd_data;

   logic [3:0]     grp_red;
   logic [GW-1:0]  grp_mod, enq_grp;
   logic           grt_waiting;
   logic [NW-1:0]  grt_head, grt_tail, link_fresh, link_eff;
   logic [GW-1:0]  order_head_inc, order_tail_inc;

   gfq_ram #(.WIDTH(GW), .DEPTH(ELEMENT_COUNT)) u_membership (
      .clock, .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr), .rd_data(mem_rd_data));
   gfq_ram #(.WIDTH(10), .DEPTH(CAPACITY)) u_node_element (
      .clock, .wr_en(elm_wr_en), .wr_addr(elm_wr_addr), .wr_data(elm_wr_data),
      .rd_addr(elm_rd_addr), .rd_data(elm_rd_data));
   gfq_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_node_link (
      .clock, .wr_en(lnk_wr_en), .wr_addr(lnk_wr_addr), .wr_data(lnk_wr_data),
      .rd_addr(lnk_rd_addr), .rd_data(lnk_rd_data));
   gfq_ram #(.WIDTH(GD), .DEPTH(GROUP_COUNT)) u_group_table (
      .clock, .wr_en(grt_wr_en), .wr_addr(grt_wr_addr), .wr_data(grt_wr_data),
      .rd_addr(grt_rd_addr), .rd_data(grt_rd_data));
   gfq_ram #(.WIDTH(GW), .DEPTH(GROUP_COUNT)) u_order_ring (
      .clock, .wr_en(ord_wr_en), .wr_addr(ord_wr_addr), .wr_data(ord_wr_data),
      .rd_addr(ord_rd_addr), .rd_data(ord_rd_data));

   // group number reduced modulo the group count by repeated subtraction
   always_comb begin
      grp_red = req_group;
      for (int i = 0; i < 8; i++) begin
         if (32'(grp_red) >= GROUP_COUNT) begin
            grp_red = grp_red - 4'(GROUP_COUNT);
         end
      end
      grp_mod = GW'(grp_red);
   end

   assign enq_grp     = in_range_ff ? mem_rd_data : '0;
   assign grt_waiting = grt_rd_data[GD-1];
   assign grt_head    = grt_rd_data[2*NW-1:NW];
   assign grt_tail    = grt_rd_data[NW-1:0];

   // links at or past the fill mark were never written; the free chain there is node + 1
   assign link_fresh = (node_ff == NW'(CAPACITY - 1)) ? '0 : node_ff + 1'b1;
   assign link_eff   = (CW'(node_ff) >= fill_ff) ? link_fresh : lnk_rd_data;

   assign order_head_inc = (order_head_ff == GW'(GROUP_COUNT - 1)) ? '0 : order_head_ff + 1'b1;
   assign order_tail_inc = (order_tail_ff == GW'(GROUP_COUNT - 1)) ? '0 : order_tail_ff + 1'b1;

   assign flags.full        = (stored_ff == CW'(CAPACITY));
   assign flags.order_empty = (order_count_ff == '0);
   assign flags.waiting     = grt_waiting;
   assign flags.sweep_done  = (sweep_ff == SW'(SWEEP_LEN - 1));

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = EW'(elem_ff);
      mem_wr_data = grp_in_ff;
      mem_rd_addr = EW'(elem_ff);
      elm_wr_en   = 1'b0;
      elm_wr_addr = node_ff;
      elm_wr_data = elem_ff;
      elm_rd_addr = grt_head;
      lnk_wr_en   = 1'b0;
      lnk_wr_addr = node_ff;
      lnk_wr_data = '0;
      lnk_rd_addr = grt_head;
      grt_wr_en   = 1'b0;
      grt_wr_addr = grp_ff;
      grt_wr_data = '0;
      grt_rd_addr = enq_grp;
      ord_wr_en   = 1'b0;
      ord_wr_addr = order_tail_ff;
      ord_wr_data = grp_ff;
      ord_rd_addr = order_head_ff;
      case (cmd)
         CMD_ASSIGN: begin
            mem_wr_en = in_range_ff;
         end
         CMD_ENQ_GROUP: begin
            grt_rd_addr = enq_grp;
            lnk_rd_addr = free_head_ff;
         end
         CMD_ENQ_LINK: begin
            elm_wr_en   = 1'b1;
            lnk_wr_en   = 1'b1;
            grt_wr_en   = 1'b1;
            grt_wr_data = grt_waiting ? {1'b1, grt_head, node_ff} : {1'b1, node_ff, node_ff};
            ord_wr_en   = !grt_waiting && (32'(order_count_ff) < GROUP_COUNT);
         end
         CMD_ENQ_TAIL: begin
            lnk_wr_en   = 1'b1;
            lnk_wr_addr = tail_ff;
            lnk_wr_data = node_ff;
         end
         CMD_DEQ_GROUP: begin
            grt_rd_addr = ord_rd_data;
         end
         CMD_DEQ_POP: begin
            grt_wr_en   = 1'b1;
            grt_wr_data = (tail_ff == node_ff) ? {1'b0, node_ff, tail_ff}
                                               : {1'b1, link_eff, tail_ff};
            lnk_wr_en   = 1'b1;
            lnk_wr_data = free_head_ff;
         end
         CMD_SWEEP: begin
            mem_wr_en   = (32'(sweep_ff) < ELEMENT_COUNT);
            mem_wr_addr = EW'(sweep_ff);
            mem_wr_data = '0;
            grt_wr_en   = (32'(sweep_ff) < GROUP_COUNT);
            grt_wr_addr = GW'(sweep_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_CAPTURE: begin
            elem_ff     <= req_element;
            in_range_ff <= (32'(req_element) < ELEMENT_COUNT);
            grp_in_ff   <= grp_mod;
         end
         CMD_ASSIGN, CMD_ENQ_LOOKUP: begin
            pend_status_ff <= ST_DONE;
            pend_elem_ff   <= '0;
         end
         CMD_ENQ_GROUP: begin
            grp_ff  <= enq_grp;
            node_ff <= free_head_ff;
            if (flags.full) begin
               pend_status_ff <= ST_FULL;
            end
         end
         CMD_ENQ_LINK: begin
            tail_ff <= grt_tail;
         end
         CMD_DEQ_ORDER: begin
            pend_status_ff <= ST_EMPTY;
            pend_elem_ff   <= '0;
         end
         CMD_DEQ_GROUP: begin
            grp_ff <= ord_rd_data;
         end
         CMD_DEQ_NODE: begin
            node_ff <= grt_head;
            tail_ff <= grt_tail;
         end
         CMD_DEQ_POP: begin
            pend_status_ff <= ST_DEQUEUED;
            pend_elem_ff   <= elm_rd_data;
         end
         CMD_SWEEP: begin
            pend_status_ff <= ST_DONE;
            pend_elem_ff   <= '0;
         end
         CMD_RESULT: begin
            rsp_status_ff <= pend_status_ff;
            rsp_elem_ff   <= pend_elem_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff   <= '0;
         fill_ff        <= '0;
         stored_ff      <= '0;
         order_head_ff  <= '0;
         order_tail_ff  <= '0;
         order_count_ff <= '0;
         sweep_ff       <= '0;
      end else begin
         case (cmd)
            CMD_ENQ_LINK: begin
               free_head_ff <= link_eff;
               stored_ff    <= stored_ff + 1'b1;
               if (CW'(node_ff) == fill_ff) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               if (!grt_waiting && (32'(order_count_ff) < GROUP_COUNT)) begin
                  order_tail_ff  <= order_tail_inc;
                  order_count_ff <= order_count_ff + 1'b1;
               end
            end
            CMD_DEQ_POP: begin
               free_head_ff <= node_ff;
               if (stored_ff != '0) begin
                  stored_ff <= stored_ff - 1'b1;
               end
               if (tail_ff == node_ff) begin
                  order_head_ff  <= order_head_inc;
                  order_count_ff <= order_count_ff - 1'b1;
               end
            end
            CMD_SWEEP: begin
               free_head_ff   <= '0;
               fill_ff        <= '0;
               stored_ff      <= '0;
               order_head_ff  <= '0;
               order_tail_ff  <= '0;
               order_count_ff <= '0;
               sweep_ff       <= flags.sweep_done ? '0 : sweep_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_dequeued_element = rsp_elem_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

`default_nettype wire

### hdl/grouped_fifo_queue.sv
// top level of the team queue
`default_nettype none

// Team queue: elements are enqueued behind earlier members of their own group, groups are
// served in the order they first became non-empty. One operation is taken at a time; a new
// one is accepted while the previous result still waits on the rsp side. From accept to
// result load, assign writes membership; enqueue looks up the group, reads its entry (ending
// on a full store), links the node and, if the group waits, the old tail; dequeue reads the
// order ring (ending if empty), group entry and node, then pops. The next request is taken
// in the idle state after the load. Each step is one registered read of the membership,
// group or node memories feeding the next address. While the result register is stalled, the
// following operation holds in its last step until the register frees. After reset and after
// a clear, a clearing pass zeroes membership and group tables; no request is taken during it.
module grouped_fifo_queue
   import gfq_pkg::*;
#(
   parameter int ELEMENT_COUNT = 1024,
   parameter int GROUP_COUNT   = 16,
   parameter int CAPACITY      = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [9:0] req_element,
   input  wire logic [3:0] req_group,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [9:0] rsp_dequeued_element,
   output logic      [1:0] rsp_status
);

   gfq_cmd_type   cmd;
   gfq_flags_type flags;

   gfq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_operation,
      .rsp_valid, .rsp_stall, .cmd, .flags);

   gfq_dpath #(
      .ELEMENT_COUNT(ELEMENT_COUNT),
      .GROUP_COUNT(GROUP_COUNT),
      .CAPACITY(CAPACITY)
   ) u_dpath (
      .clock, .reset, .cmd, .flags, .req_element, .req_group,
      .rsp_dequeued_element, .rsp_status);

   // clearing pass follows reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken right after reset");

   // one beat in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken back to back");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DEQUEUED) |-> rsp_dequeued_element == '0)
      else $error("element on a non-dequeue result");

   // a full store always has some group queued
   assert property (@(posedge clock) disable iff (reset)
      flags.full |-> !flags.order_empty)
      else $error("full store with empty group order");

endmodule

`default_nettype wire
